[sv/uint128_string_parser_assert.svh]
// Assertion macros for the checker module of the string parser.
// Clock clk_i and active-low reset rst_ni are assumed in scope.
`ifndef UINT128_STRING_PARSER_ASSERT_SVH
`define UINT128_STRING_PARSER_ASSERT_SVH

// Same-cycle implication
`define U128SP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define U128SP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/u128sp_pkg.sv]
package u128sp_pkg;

  // Parse phase codes
  localparam logic [1:0] PH_START   = 2'd0;
  localparam logic [1:0] PH_ZERO    = 2'd1;
  localparam logic [1:0] PH_DIGITS  = 2'd2;
  localparam logic [1:0] PH_STOPPED = 2'd3;

  // Radix codes
  localparam logic [1:0] RX_DEC = 2'd0;
  localparam logic [1:0] RX_OCT = 2'd1;
  localparam logic [1:0] RX_HEX = 2'd2;

  // Character codes
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_DIG0 = 8'h30;
  localparam logic [7:0] CH_DIG7 = 8'h37;
  localparam logic [7:0] CH_DIG9 = 8'h39;
  localparam logic [7:0] CH_UC_A = 8'h41;
  localparam logic [7:0] CH_UC_F = 8'h46;
  localparam logic [7:0] CH_LC_A = 8'h61;
  localparam logic [7:0] CH_LC_F = 8'h66;
  localparam logic [7:0] CH_LC_X = 8'h78;

  localparam int unsigned AccW  = 128;
  localparam int unsigned HalfW = 64;
  // Product width: accumulator times at most 16
  localparam int unsigned ProdW = AccW + 4;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  // Digit value of a character in the given radix
  function automatic digit_t digit_of(logic [7:0] ch, logic [1:0] rx);
    digit_t d;
    d.ok  = 1'b0;
    d.val = 4'd0;
    if (rx == RX_OCT) begin
      if (ch >= CH_DIG0 && ch <= CH_DIG7) begin
        d.ok  = 1'b1;
        d.val = ch[3:0];
      end
    end else if (ch >= CH_DIG0 && ch <= CH_DIG9) begin
      d.ok  = 1'b1;
      d.val = ch[3:0];
    end else if (rx == RX_HEX && ((ch >= CH_LC_A && ch <= CH_LC_F) ||
                                  (ch >= CH_UC_A && ch <= CH_UC_F))) begin
      // low nibble of a..f / A..F is 1..6
      d.ok  = 1'b1;
      d.val = ch[3:0] + 4'd9;
    end
    return d;
  endfunction

endpackage

[sv/uint128_string_parser.sv]
// Streaming parser of an unsigned 128-bit integer, one character per
// transaction. A C-style prefix picks the base ("0x" hex, leading 0 octal,
// otherwise decimal); parsing stops at the first non-digit and a zero byte
// ends the string, producing one result transaction with the value, a valid
// flag and a wrap flag. One character is taken every clock cycle unless the
// input stalls; the rate is set by the accumulator loop, which does the
// 128-bit multiply-by-base plus digit combinationally. A character passes
// through an input register, then the state update; a terminator in the
// input register loads the result register once the output is free. The
// input stalls only when a terminator meets a result still waiting on output.
module uint128_string_parser
  import u128sp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       character_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [HalfW-1:0] value_high_o,
  output logic [HalfW-1:0] value_low_o,
  output logic             valid_res_o,
  output logic             overflowed_o
);

  // Input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] ch_q;

  // Parse state
  logic [1:0]      phase_q, phase_d;
  logic [1:0]      radix_q, radix_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic            seen_q, seen_d;
  logic            wrap_q, wrap_d;

  // Result register
  logic             out_vld_q, out_vld_d;
  logic [AccW-1:0]  res_val_q;
  logic             res_ok_q, res_ovf_q;

  logic            out_free, is_term, advance, res_load, res_ok;
  logic [1:0]      eff_radix;
  digit_t          dig;
  logic [ProdW-1:0] prod, full;
  logic            wrap_now;

  // Handshake
  assign out_free   = !out_vld_q || out_ready_i;
  assign is_term    = (ch_q == CH_NUL);
  assign advance    = in_vld_q && (!is_term || out_free);
  assign res_load   = advance && is_term;
  assign in_ready_o = !in_vld_q || advance;
  assign in_vld_d   = in_ready_o ? in_valid_i : in_vld_q;

  // Radix in force for this character: start is decimal, after a leading 0 octal
  always_comb begin
    unique case (phase_q)
      PH_START: eff_radix = RX_DEC;
      PH_ZERO:  eff_radix = RX_OCT;
      default:  eff_radix = radix_q;
    endcase
  end

  assign dig = digit_of(ch_q, eff_radix);

  // acc * base + digit, kept wide to see the wrap
  always_comb begin
    unique case (eff_radix)
      RX_OCT:  prod = {1'b0, acc_q, 3'b000};
      RX_HEX:  prod = {acc_q, 4'b0000};
      default: prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
    endcase
    full     = prod + {{(ProdW-4){1'b0}}, dig.val};
    wrap_now = |full[ProdW-1:AccW];
  end

  assign res_ok = (phase_q == PH_ZERO) || seen_q;

  // Next parse state
  always_comb begin
    phase_d = phase_q;
    radix_d = radix_q;
    acc_d   = acc_q;
    seen_d  = seen_q;
    wrap_d  = wrap_q;
    if (advance) begin
      if (is_term) begin
        phase_d = PH_START;
        radix_d = RX_DEC;
        acc_d   = '0;
        seen_d  = 1'b0;
        wrap_d  = 1'b0;
      end else begin
        unique case (phase_q)
          PH_START: begin
            if (ch_q == CH_DIG0) begin
              phase_d = PH_ZERO;
            end else begin
              radix_d = RX_DEC;
              phase_d = dig.ok ? PH_DIGITS : PH_STOPPED;
            end
          end
          PH_ZERO: begin
            if (ch_q == CH_LC_X) begin
              radix_d = RX_HEX;
              phase_d = PH_DIGITS;
            end else begin
              radix_d = RX_OCT;
              phase_d = dig.ok ? PH_DIGITS : PH_STOPPED;
            end
          end
          PH_DIGITS: begin
            if (!dig.ok) begin
              phase_d = PH_STOPPED;
            end
          end
          PH_STOPPED: begin
            phase_d = PH_STOPPED;
          end
        endcase
        // Accumulate a digit, but not the leading 0 or the 'x' of the hex prefix
        if (dig.ok && (phase_q == PH_DIGITS ||
                       (phase_q == PH_START && ch_q != CH_DIG0) ||
                       (phase_q == PH_ZERO && ch_q != CH_LC_X))) begin
          acc_d  = full[AccW-1:0];
          seen_d = 1'b1;
          wrap_d = wrap_q || wrap_now;
        end
      end
    end
  end

  // Output valid
  always_comb begin
    if (res_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      phase_q   <= PH_START;
      radix_q   <= RX_DEC;
      acc_q     <= '0;
      seen_q    <= 1'b0;
      wrap_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      phase_q   <= phase_d;
      radix_q   <= radix_d;
      acc_q     <= acc_d;
      seen_q    <= seen_d;
      wrap_q    <= wrap_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      ch_q <= character_i;
    end
    if (res_load) begin
      res_val_q <= res_ok ? acc_q : '0;
      res_ok_q  <= res_ok;
      res_ovf_q <= res_ok && wrap_q;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign value_high_o = res_val_q[AccW-1:HalfW];
  assign value_low_o  = res_val_q[HalfW-1:0];
  assign valid_res_o  = res_ok_q;
  assign overflowed_o = res_ovf_q;

endmodule

[sv/u128sp_checker.sv]
`include "uint128_string_parser_assert.svh"

module u128sp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  character_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] value_high_o,
  input logic [63:0] value_low_o,
  input logic        valid_res_o,
  input logic        overflowed_o
);

  // Stalled result transaction holds
  `U128SP_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(value_high_o) && $stable(value_low_o) && $stable(valid_res_o) && $stable(overflowed_o), "result changed while stalled")

  // Failed parse gives an all-zero result
  `U128SP_ASSERT_NOW(a_fail_zero, out_valid_o && !valid_res_o, value_high_o == 64'd0 && value_low_o == 64'd0 && !overflowed_o, "failed parse with non-zero fields")

  // Wrap only reported on a good parse
  `U128SP_ASSERT_NOW(a_ovf_ok, out_valid_o && overflowed_o, valid_res_o, "overflow without valid result")

  // An empty output never holds back the input
  `U128SP_ASSERT_NOW(a_ready_free, !out_valid_o, in_ready_o, "input stalled with output empty")

endmodule

bind uint128_string_parser u128sp_checker u_chk (.*);
